### rtl/hefa_pkg.sv
package hefa_pkg;

  localparam int MAX_FRAME = 258;
  localparam logic [7:0] H4_EVENT_TYPE = 8'h04;
  localparam logic [8:0] LIMIT_RESET = 9'd258;

  // output queue holds two words per input word plus slack for one stall
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [7:0] frame_byte;
    logic [8:0] byte_index;
    logic       last_byte;
    logic       frame_error;
  } result_t;

  typedef struct packed {
    logic    first_valid;
    logic    second_valid;
    result_t first;
    result_t second;
  } push_t;

endpackage

### rtl/hefa_parser.sv
module hefa_parser import hefa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_fire,
  input  logic [7:0] rx_byte,
  input  logic [8:0] delivery_limit,
  output push_t      push
);

  logic       hunting, hunting_next;
  logic [8:0] bytes_taken, bytes_taken_next;
  logic [8:0] bytes_needed, bytes_needed_next;
  logic [7:0] held_event_code, held_event_code_next;

  logic [9:0] total;
  logic [9:0] idx_inc;
  logic [9:0] limit_ext;
  logic [8:0] taken_after;
  logic [8:0] needed_after;

  assign total     = 10'd2 + {2'b00, rx_byte};
  assign idx_inc   = {1'b0, bytes_taken} + 10'd1;
  assign limit_ext = {1'b0, delivery_limit};

  always_comb begin
    hunting_next         = hunting;
    bytes_taken_next     = bytes_taken;
    bytes_needed_next    = bytes_needed;
    held_event_code_next = held_event_code;
    taken_after          = bytes_taken;
    needed_after         = bytes_needed;
    push                 = '0;
    if (in_fire) begin
      if (hunting) begin
        if (rx_byte == H4_EVENT_TYPE) begin
          hunting_next      = 1'b0;
          bytes_taken_next  = '0;
          bytes_needed_next = 9'd2;
        end
      end else if (bytes_taken == 9'd0) begin
        held_event_code_next = rx_byte;
        bytes_taken_next     = 9'd1;
      end else if (bytes_taken == 9'd1) begin
        if (total > 10'(MAX_FRAME)) begin
          push.first_valid       = 1'b1;
          push.first.frame_byte  = rx_byte;
          push.first.byte_index  = 9'd1;
          push.first.frame_error = 1'b1;
          hunting_next           = 1'b1;
          bytes_taken_next       = '0;
          bytes_needed_next      = '0;
        end else begin
          needed_after = total[8:0];
          taken_after  = 9'd2;
          // code word, then length word, each only if under the limit
          if (delivery_limit != 9'd0) begin
            push.first_valid      = 1'b1;
            push.first.frame_byte = held_event_code;
            push.first.byte_index = 9'd0;
            push.first.last_byte  = (total == 10'd1) || (limit_ext == 10'd1);
          end
          if (delivery_limit > 9'd1) begin
            push.second_valid      = 1'b1;
            push.second.frame_byte = rx_byte;
            push.second.byte_index = 9'd1;
            push.second.last_byte  = (total == 10'd2) || (limit_ext == 10'd2);
          end
          bytes_needed_next = needed_after;
          bytes_taken_next  = taken_after;
          if (taken_after >= needed_after) begin
            hunting_next      = 1'b1;
            bytes_taken_next  = '0;
            bytes_needed_next = '0;
          end
        end
      end else begin
        taken_after = idx_inc[8:0];
        if (bytes_taken < delivery_limit) begin
          push.first_valid      = 1'b1;
          push.first.frame_byte = rx_byte;
          push.first.byte_index = bytes_taken;
          push.first.last_byte  = (idx_inc == {1'b0, bytes_needed}) ||
                                  (idx_inc == limit_ext);
        end
        bytes_taken_next = taken_after;
        if (taken_after >= bytes_needed) begin
          hunting_next      = 1'b1;
          bytes_taken_next  = '0;
          bytes_needed_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hunting         <= 1'b1;
      bytes_taken     <= '0;
      bytes_needed    <= '0;
      held_event_code <= '0;
    end else begin
      hunting         <= hunting_next;
      bytes_taken     <= bytes_taken_next;
      bytes_needed    <= bytes_needed_next;
      held_event_code <= held_event_code_next;
    end
  end

endmodule

### rtl/hefa_out_fifo.sv
module hefa_out_fifo import hefa_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    has_room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_word
);

  result_t mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] count;
  logic [FIFO_CW-1:0] n_push;
  logic               pop;
  logic [FIFO_AW-1:0] second_ptr;

  assign has_room   = count <= FIFO_CW'(FIFO_DEPTH - 2);
  assign out_valid  = count != '0;
  assign out_word   = mem[rd_ptr];
  assign pop        = out_valid && out_ready;
  assign n_push     = FIFO_CW'(push.first_valid) + FIFO_CW'(push.second_valid);
  assign second_ptr = push.first_valid ? wr_ptr + FIFO_AW'(1) : wr_ptr;

  always_ff @(posedge clk) begin
    if (push.first_valid) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.second_valid) begin
      mem[second_ptr] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push[FIFO_AW-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      count <= count + n_push - FIFO_CW'(pop);
    end
  end

endmodule

### rtl/hci_event_frame_assembler.sv
// channel      dir  tdata fields (low bit up)               tlast      tuser
// s_axis       in   rx_byte[7:0]                             -          -
// m_axis       out  frame_byte[7:0], byte_index[16:8]        last_byte  frame_error
// cfg          in   cfg_wr_data = delivery_limit[8:0], written when cfg_wr_en
//
// one input word is taken per cycle; its results are written into the output
// queue at the accepting edge, can leave from the next edge on, one word per cycle.
// a length word can make two results, so a four-entry queue takes input only
// while two entries are free.
// rst is synchronous and puts the parser back to hunting with the queue empty.
// a stall on m_axis backs up into s_axis_tready once the queue fills.
module hci_event_frame_assembler import hefa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // frame_byte, byte_index, zero pad
  output logic        m_axis_tlast,   // last_byte
  output logic [0:0]  m_axis_tuser,   // frame_error
  input  logic        cfg_wr_en,
  input  logic [8:0]  cfg_wr_data
);

  logic [8:0] delivery_limit;
  logic       in_fire;
  push_t      push;
  result_t    out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      delivery_limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      delivery_limit <= cfg_wr_data;
    end
  end

  assign in_fire = s_axis_tvalid && s_axis_tready;

  hefa_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .in_fire        (in_fire),
    .rx_byte        (s_axis_tdata),
    .delivery_limit (delivery_limit),
    .push           (push)
  );

  hefa_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .has_room  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_word  (out_word)
  );

  assign m_axis_tdata = {7'd0, out_word.byte_index, out_word.frame_byte};
  assign m_axis_tlast = out_word.last_byte;
  assign m_axis_tuser = out_word.frame_error;

endmodule

### test/tb_hci_event_frame_assembler.sv
module tb_hci_event_frame_assembler;
  timeunit 1ns;
  timeprecision 1ps;

  import hefa_pkg::*;

  localparam int FRAMED_BYTE_GOAL = 1550;
  localparam int QUIET_CYCLES = 8;
  localparam int MAX_PRINTED = 40;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // frame_byte[7:0], byte_index[16:8], zero pad
  logic        m_axis_tlast;   // last_byte
  logic [0:0]  m_axis_tuser;   // frame_error
  logic        cfg_wr_en;
  logic [8:0]  cfg_wr_data;

  // deframer state as the block should hold it
  logic [8:0] limit_q;
  logic       hunting_q;
  logic [8:0] taken_q;
  logic [8:0] needed_q;
  logic [7:0] code_q;

  result_t frame_words_due[$];
  int      framed_byte_count;
  int      mismatch_count;
  bit      src_steady;
  bit      sink_steady;

  hci_event_frame_assembler u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void push_word(logic [7:0] b, logic [8:0] idx, logic last, logic err);
    result_t w;
    w.frame_byte  = b;
    w.byte_index  = idx;
    w.last_byte   = last;
    w.frame_error = err;
    frame_words_due.push_back(w);
  endfunction

  function automatic logic marks_last(int idx, int total);
    return (idx + 1 == total) || (idx + 1 == int'(limit_q));
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    int total;
    int idx;
    if (hunting_q) begin
      if (b == H4_EVENT_TYPE) begin
        hunting_q = 1'b0;
        taken_q = 9'd0;
        needed_q = 9'd2;
        framed_byte_count++;
      end
      return;
    end
    framed_byte_count++;
    if (taken_q == 9'd0) begin
      code_q = b;
      taken_q = 9'd1;
      return;
    end
    if (taken_q == 9'd1) begin
      total = 2 + int'(b);
      if (total > MAX_FRAME) begin
        push_word(b, 9'd1, 1'b0, 1'b1);
        hunting_q = 1'b1;
        taken_q = 9'd0;
        needed_q = 9'd0;
        return;
      end
      needed_q = 9'(total);
      if (limit_q > 9'd0) push_word(code_q, 9'd0, marks_last(0, total), 1'b0);
      if (limit_q > 9'd1) push_word(b, 9'd1, marks_last(1, total), 1'b0);
      taken_q = 9'd2;
    end else begin
      idx = int'(taken_q);
      // past the delivery limit the word is swallowed
      if (idx < int'(limit_q)) push_word(b, 9'(idx), marks_last(idx, int'(needed_q)), 1'b0);
      taken_q = 9'(idx + 1);
    end
    if (taken_q >= needed_q) begin
      hunting_q = 1'b1;
      taken_q = 9'd0;
      needed_q = 9'd0;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < MAX_PRINTED)
      $display("mismatch at %0t ns: %s got 0x%0h want 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_words
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (frame_words_due.size() == 0) begin
        report_mismatch("word with none due, tdata", 32'(m_axis_tdata), 32'd0);
      end else begin
        want = frame_words_due.pop_front();
        if (m_axis_tdata[7:0] !== want.frame_byte)
          report_mismatch("frame_byte", 32'(m_axis_tdata[7:0]), 32'(want.frame_byte));
        if (m_axis_tdata[16:8] !== want.byte_index)
          report_mismatch("byte_index", 32'(m_axis_tdata[16:8]), 32'(want.byte_index));
        if (m_axis_tlast !== want.last_byte)
          report_mismatch("last_byte", 32'(m_axis_tlast), 32'(want.last_byte));
        if (m_axis_tuser[0] !== want.frame_error)
          report_mismatch("frame_error", 32'(m_axis_tuser[0]), 32'(want.frame_error));
      end
    end
  end

  // receiver: random stall before each word, none while sink_steady
  initial begin : receiver
    int stall;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = sink_steady ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    deframe_byte(b);
  endtask

  function automatic logic [7:0] param_byte();
    case ($urandom_range(0, 7))
      0: return H4_EVENT_TYPE;
      1: return 8'h00;
      2: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // sends type, code and length, then the first sent_params parameter words
  task automatic send_frame(input logic [7:0] code, input int len, input int sent_params);
    send_byte(H4_EVENT_TYPE);
    send_byte(code);
    send_byte(8'(len));
    repeat (sent_params) send_byte(param_byte());
  endtask

  // hold off input until everything due has come out, then let the pipe empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (frame_words_due.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [8:0] v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    limit_q = v;
  endtask

  task automatic test_header_cases();
    // stray words while hunting are dropped
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h05);
    // empty parameter list ends on the length word
    send_byte(H4_EVENT_TYPE);
    send_byte(8'h00);
    send_byte(8'h00);
    // a repeated type word is taken as the event code
    send_byte(H4_EVENT_TYPE);
    send_byte(H4_EVENT_TYPE);
    send_byte(8'h03);
    send_byte(H4_EVENT_TYPE);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(H4_EVENT_TYPE);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'h80);
  endtask

  task automatic test_limit_sweep();
    int sweep[10] = '{0, 1, 2, 3, 4, 5, 257, 258, 259, 511};
    int lens[5] = '{0, 1, 2, 3, 6};
    foreach (sweep[i]) begin
      write_limit(9'(sweep[i]));
      foreach (lens[j]) send_frame(8'($urandom_range(0, 255)), lens[j], lens[j]);
    end
  endtask

  task automatic test_limit_mid_frame();
    // limit drops below the current index: rest of the frame is swallowed
    write_limit(9'd258);
    send_frame(8'h0E, 10, 3);
    write_limit(9'd4);
    repeat (7) send_byte(param_byte());
    // limit falls inside the frame, short of its end, so the frame stays open
    write_limit(9'd258);
    send_frame(8'h0F, 6, 2);
    write_limit(9'd6);
    repeat (2) send_byte(param_byte());
    // limit of one set after type and code words, which here close the open frame
    write_limit(9'd258);
    send_byte(H4_EVENT_TYPE);
    send_byte(8'h3E);
    write_limit(9'd1);
    send_byte(8'h03);
    repeat (3) send_byte(param_byte());
  endtask

  task automatic test_longest_frames();
    src_steady = 1'b1;
    write_limit(9'd258);
    send_frame(8'hFF, 255, 255);
    src_steady = 1'b0;
    write_limit(9'd100);
    send_frame(8'h13, 150, 150);
    write_limit(9'd257);
    send_frame(8'h00, 254, 254);
  endtask

  task automatic test_random_traffic();
    int len;
    int cut;
    while (framed_byte_count < FRAMED_BYTE_GOAL) begin
      src_steady  = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0: write_limit(9'd0);
        1: write_limit(9'd511);
        2: write_limit(9'($urandom_range(259, 511)));
        3: write_limit(9'($urandom_range(1, 4)));
        default: write_limit(9'($urandom_range(1, MAX_FRAME)));
      endcase
      repeat ($urandom_range(2, 8)) begin
        // line noise, sometimes a stray type word that opens a bogus frame
        repeat ($urandom_range(0, 2))
          send_byte(($urandom_range(0, 7) == 0) ? H4_EVENT_TYPE : 8'($urandom_range(0, 255)));
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : len;
        send_frame(8'($urandom_range(0, 255)), len, cut);
      end
    end
    src_steady  = 1'b0;
    sink_steady = 1'b0;
  endtask

  initial begin
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= 9'd0;
    limit_q   = LIMIT_RESET;
    hunting_q = 1'b1;
    taken_q   = 9'd0;
    needed_q  = 9'd0;
    code_q    = 8'h00;
    framed_byte_count = 0;
    mismatch_count    = 0;
    src_steady  = 1'b0;
    sink_steady = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_header_cases();
    test_limit_sweep();
    test_limit_mid_frame();
    test_longest_frames();
    test_random_traffic();

    settle();
    repeat (12) @(posedge clk);
    if (mismatch_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #8ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
